### sv/sliding_window_min_dedup_core_defines.svh
// ---------------------------------------------------------------------------
// Sliding window minimum dedup - assertion macros
// Shared concurrent assertion forms; expect clk and rst in scope.
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MIN_DEDUP_CORE_DEFINES_SVH
`define SLIDING_WINDOW_MIN_DEDUP_CORE_DEFINES_SVH

// same-cycle implication
`define SWMD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/swmd_pkg.sv
// ---------------------------------------------------------------------------
// Sliding window minimum dedup - package
// Shared sizes, types and lane/stage records.
// ---------------------------------------------------------------------------
package swmd_pkg;

  localparam int LANES         = 8;
  localparam int LANE_IDX_BITS = $clog2(LANES);
  localparam int VALUE_BITS    = 22;
  localparam int COUNT_BITS    = 4;
  localparam int WINDOW_LEN    = 4;
  localparam int FILL_BITS     = $clog2(WINDOW_LEN + 1);
  localparam int SUM_BITS      = FILL_BITS + COUNT_BITS;
  localparam int EXT_LEN       = WINDOW_LEN + LANES - 1;
  // window rounded up to a power of two for the min tree
  localparam int TREE_LEN      = 1 << $clog2(WINDOW_LEN);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [FILL_BITS-1:0]  fill_t;

  // entry 0 is the newest value
  typedef value_t [WINDOW_LEN-1:0] window_t;
  typedef value_t [LANES-1:0]      lane_vals_t;

  typedef struct packed {
    logic active;
    logic full;
    logic prev_elig;
  } lane_ctl_t;

  typedef struct packed {
    value_t wmin;
    logic   elig;
    logic   emit;
  } lane_res_t;

  typedef struct packed {
    lane_vals_t       mins;
    logic [LANES-1:0] emit;
  } merge_req_t;

endpackage

### sv/swmd_lane.sv
// ---------------------------------------------------------------------------
// Sliding window minimum dedup - lane
// Window minimum of one lane position and its emit decision.
// ---------------------------------------------------------------------------
module swmd_lane import swmd_pkg::*; (
  input  window_t   taps,
  input  lane_ctl_t ctl,
  input  value_t    prev_min,
  input  value_t    last_emitted,
  output lane_res_t res
);

  // pairwise min tree, padded with all ones
  function automatic value_t win_min(input window_t w);
    value_t t [TREE_LEN];
    for (int k = 0; k < TREE_LEN; k++) begin
      t[k] = '1;
      if (k < WINDOW_LEN) begin
        t[k] = w[k];
      end
    end
    for (int s = 1; s < TREE_LEN; s = s * 2) begin
      for (int k = 0; k + s < TREE_LEN; k = k + 2 * s) begin
        if (t[k+s] < t[k]) begin
          t[k] = t[k+s];
        end
      end
    end
    return t[0];
  endfunction

  value_t ref_min;

  // the previous eligible lane either emitted its minimum or matched it
  assign ref_min  = ctl.prev_elig ? prev_min : last_emitted;
  assign res.wmin = win_min(taps);
  assign res.elig = ctl.active && ctl.full;
  assign res.emit = res.elig && (res.wmin != ref_min);

endmodule

### sv/swmd_merge.sv
// ---------------------------------------------------------------------------
// Sliding window minimum dedup - merge stage
// Pack emitted lane minima in lane order into the output register.
// ---------------------------------------------------------------------------
`include "sliding_window_min_dedup_core_defines.svh"

module swmd_merge import swmd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  merge_req_t req,
  output logic       out_valid,
  input  logic       out_ready,
  output lane_vals_t mins,
  output count_t     count
);

  lane_vals_t packed_next;
  count_t     count_next;

  always_comb begin
    packed_next = '0;
    count_next  = '0;
    for (int i = 0; i < LANES; i++) begin
      if (req.emit[i]) begin
        packed_next[count_next[LANE_IDX_BITS-1:0]] = req.mins[i];
        count_next = count_next + count_t'(1);
      end
    end
  end

  assign req_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req_ready) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      mins  <= packed_next;
      count <= count_next;
    end
  end

  `SWMD_ASSERT_IMPL(a_end_result_zero, out_valid && count == '0, mins == '0,
    "end-of-stream result carries nonzero minima")
  `SWMD_ASSERT_NEXT(a_request_lands, req_valid && req_ready, out_valid,
    "taken request did not reach the output register")

endmodule

### sv/sliding_window_min_dedup_core.sv
// ---------------------------------------------------------------------------
// Sliding window minimum dedup - top level
// Eight-lane window minimum with suppression of repeated minima.
// ---------------------------------------------------------------------------
// Takes one eight-lane beat per clock cycle while the output is not stalled
// and returns at most one result per beat, via the s1 and merge output
// registers. The window, fill level and last emitted minimum advance at
// acceptance for all eight lanes at once; that update across the lanes (a
// window minimum per lane and a previous-lane compare) sets the rate. A
// lane_count of zero ends the stream: it yields an all-zero result and
// returns the state to reset. Beats that emit no minimum give no result.
`include "sliding_window_min_dedup_core_defines.svh"

module sliding_window_min_dedup_core import swmd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  value_t value_0,
  input  value_t value_1,
  input  value_t value_2,
  input  value_t value_3,
  input  value_t value_4,
  input  value_t value_5,
  input  value_t value_6,
  input  value_t value_7,
  input  count_t lane_count,
  output logic   out_valid,
  input  logic   out_ready,
  output value_t min_0,
  output value_t min_1,
  output value_t min_2,
  output value_t min_3,
  output value_t min_4,
  output value_t min_5,
  output value_t min_6,
  output value_t min_7,
  output count_t min_count
);

  window_t win;
  fill_t   fill;
  value_t  last_emitted;

  window_t win_next;
  fill_t   fill_next;
  value_t  last_next;

  lane_vals_t       vals;
  lane_vals_t       eff;
  value_t           ext [EXT_LEN];
  count_t           cnt_eff;
  count_t           last_lane;
  logic             is_end;
  logic [SUM_BITS-1:0] fill_sum;
  lane_ctl_t        ctl [LANES];
  lane_res_t        res [LANES];
  logic [LANES-1:0] active_vec;
  logic [LANES-1:0] emit_vec;

  logic       s1_valid;
  logic       s1_ready;
  merge_req_t s1_data;
  merge_req_t s1_next;
  logic       in_accept;
  lane_vals_t out_mins;

  assign vals = {value_7, value_6, value_5, value_4,
                 value_3, value_2, value_1, value_0};

  assign is_end    = (lane_count == '0);
  assign cnt_eff   = (lane_count > count_t'(LANES)) ? count_t'(LANES) : lane_count;
  assign last_lane = cnt_eff - count_t'(1);

  // inactive lanes repeat the newest active value
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      active_vec[i] = (count_t'(i) < cnt_eff);
      eff[i] = active_vec[i] ? vals[i] : vals[last_lane[LANE_IDX_BITS-1:0]];
    end
  end

  // oldest first: older window entries, then this beat's lane values
  always_comb begin
    for (int j = 0; j < EXT_LEN; j++) begin
      if (j < WINDOW_LEN - 1) begin
        ext[j] = win[WINDOW_LEN-2-j];
      end else begin
        ext[j] = eff[j-WINDOW_LEN+1];
      end
    end
    for (int k = 0; k < WINDOW_LEN; k++) begin
      win_next[k] = ext[EXT_LEN-1-k];
    end
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      ctl[i].active = active_vec[i];
      ctl[i].full   = ({{COUNT_BITS{1'b0}}, fill} + SUM_BITS'(i + 1))
                      >= SUM_BITS'(WINDOW_LEN);
      ctl[i].prev_elig = 1'b0;
      if (i > 0) begin
        ctl[i].prev_elig = active_vec[i-1] &&
                           (({{COUNT_BITS{1'b0}}, fill} + SUM_BITS'(i))
                            >= SUM_BITS'(WINDOW_LEN));
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < LANES; g++) begin : g_lane
      window_t taps;
      value_t  prev_min;

      always_comb begin
        for (int k = 0; k < WINDOW_LEN; k++) begin
          taps[k] = ext[g+WINDOW_LEN-1-k];
        end
      end

      if (g == 0) begin : g_first
        assign prev_min = last_emitted;
      end else begin : g_rest
        assign prev_min = res[g-1].wmin;
      end

      swmd_lane u_lane (
        .taps         (taps),
        .ctl          (ctl[g]),
        .prev_min     (prev_min),
        .last_emitted (last_emitted),
        .res          (res[g])
      );
    end
  endgenerate

  always_comb begin
    last_next = last_emitted;
    for (int i = 0; i < LANES; i++) begin
      emit_vec[i]     = res[i].emit && !is_end;
      s1_next.mins[i] = res[i].wmin;
      if (res[i].elig) begin
        last_next = res[i].wmin;
      end
    end
    s1_next.emit = emit_vec;

    fill_sum  = {{COUNT_BITS{1'b0}}, fill} + SUM_BITS'(cnt_eff);
    fill_next = fill_sum[FILL_BITS-1:0];
    if (fill_sum >= SUM_BITS'(WINDOW_LEN)) begin
      fill_next = fill_t'(WINDOW_LEN);
    end
  end

  assign in_ready  = !s1_valid || s1_ready;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      win          <= '0;
      fill         <= '0;
      last_emitted <= '1;
      s1_valid     <= 1'b0;
    end else begin
      if (in_accept) begin
        // drop beats that emit nothing
        s1_valid <= is_end || (emit_vec != '0);
        if (is_end) begin
          win          <= '0;
          fill         <= '0;
          last_emitted <= '1;
        end else begin
          win          <= win_next;
          fill         <= fill_next;
          last_emitted <= last_next;
        end
      end else if (s1_ready) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data <= s1_next;
    end
  end

  swmd_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .req_valid (s1_valid),
    .req_ready (s1_ready),
    .req       (s1_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .mins      (out_mins),
    .count     (min_count)
  );

  assign min_0 = out_mins[0];
  assign min_1 = out_mins[1];
  assign min_2 = out_mins[2];
  assign min_3 = out_mins[3];
  assign min_4 = out_mins[4];
  assign min_5 = out_mins[5];
  assign min_6 = out_mins[6];
  assign min_7 = out_mins[7];

  `SWMD_ASSERT_NEXT(a_end_clears_state, in_accept && lane_count == '0,
    fill == '0 && last_emitted == '1, "end of stream left state behind")
  `SWMD_ASSERT_NEXT(a_fill_monotonic, in_accept && lane_count != '0,
    fill >= $past(fill), "fill level went backward within a stream")
  `SWMD_ASSERT_IMPL(a_emit_active_only, in_valid, (emit_vec & ~active_vec) == '0,
    "inactive lane emitted a minimum")

endmodule
